// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define SSSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SSSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/sssc_pkg.sv =====
package sssc_pkg;

    // Grid limits and field widths
    localparam int MAX_GRID   = 256;
    localparam int SIZE_W     = 9;    // holds 1..MAX_GRID
    localparam int COORD_W    = 8;
    localparam int INDEX_W    = 16;
    localparam int CNT_W      = 17;   // holds MAX_GRID*MAX_GRID
    localparam int RADIUS_W   = 9;
    localparam int OFFSET_W   = 10;
    localparam int CW         = 12;   // signed candidate coordinate

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0]    GRID_SIZE_RST = SIZE_W'(MAX_GRID);

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Side of the ring being walked
    typedef enum logic [1:0] {
        PH_RIGHT  = 2'd0,
        PH_LEFT   = 2'd1,
        PH_BOTTOM = 2'd2,
        PH_TOP    = 2'd3
    } t_phase;

    // Controller to datapath
    typedef struct packed {
        logic start;     // load centre and return it
        logic done;      // return an exhausted result
        logic step;      // test one candidate and advance
        logic load_out;  // move the found result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic no_scan;   // nothing started or all cells given
        logic ring_end;  // radius has reached the grid edge
        logic hit;       // current candidate lies inside the grid
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

// ===== hw/rtl/sssc_in_if.sv =====
interface sssc_in_if import sssc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_z;

    modport source (output valid, operation, center_x, center_z, input ready);
    modport sink   (input valid, operation, center_x, center_z, output ready);
endinterface

// ===== hw/rtl/sssc_out_if.sv =====
interface sssc_out_if import sssc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] cell_index;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_z;
    logic               is_last;
    logic               exhausted;

    modport source (output valid, cell_index, cell_x, cell_z, is_last, exhausted,
                     input ready);
    modport sink   (input valid, cell_index, cell_x, cell_z, is_last, exhausted,
                     output ready);
endinterface

// ===== hw/rtl/sssc_cfg.sv =====
module sssc_cfg import sssc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SIZE_W-1:0]     o_size
);

    logic [SIZE_W-1:0]    r_grid_size;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;

    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite && (w_reg_idx == REG_GRID_SIZE);
    assign pready    = 1'b1;

    // Grid size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
        end else if (w_wr) begin
            r_grid_size <= pwdata[SIZE_W-1:0];
        end
    end

    // Read back
    always_comb begin
        if (w_reg_idx == REG_GRID_SIZE) begin
            prdata = APB_DATA_W'(r_grid_size);
        end else begin
            prdata = '0;
        end
    end

    // Effective size: zero counts as one, anything above the limit is the limit
    always_comb begin
        if (r_grid_size == '0) begin
            o_size = SIZE_W'(1);
        end else if (r_grid_size > SIZE_W'(MAX_GRID)) begin
            o_size = SIZE_W'(MAX_GRID);
        end else begin
            o_size = r_grid_size;
        end
    end

endmodule

// ===== hw/rtl/sssc_ctrl.sv =====
module sssc_ctrl import sssc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_EMIT;
                    end else if (i_sts.no_scan) begin
                        o_cmd.done  = 1'b1;
                        n_state     = ST_EMIT;
                    end else begin
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.ring_end) begin
                    o_cmd.done = 1'b1;
                    n_state    = ST_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.hit) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/sssc_dp.sv =====
module sssc_dp import sssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [COORD_W-1:0] i_center_x,
    input  logic [COORD_W-1:0] i_center_z,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [INDEX_W-1:0] o_cell_index,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_z,
    output logic               o_is_last,
    output logic               o_exhausted
);

    // Walk state
    logic [COORD_W-1:0]  r_center_x;
    logic [COORD_W-1:0]  r_center_z;
    logic [RADIUS_W-1:0] r_radius;
    t_phase              r_phase;
    logic [OFFSET_W-1:0] r_offset;
    logic [CNT_W-1:0]    r_cnt;

    // Found cell, waiting for the output register
    logic [COORD_W-1:0]  r_hit_x;
    logic [COORD_W-1:0]  r_hit_z;
    logic                r_hit_last;
    logic                r_hit_exh;

    // Output register
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic [COORD_W-1:0]  r_out_x;
    logic [COORD_W-1:0]  r_out_z;
    logic                r_out_last;
    logic                r_out_exh;

    logic [CNT_W-1:0]    w_total;
    logic [SIZE_W-1:0]   w_szm1;
    logic [COORD_W-1:0]  w_clamp_x;
    logic [COORD_W-1:0]  w_clamp_z;
    logic signed [CW-1:0] w_cx, w_cz, w_r, w_off, w_sz;
    logic signed [CW-1:0] w_x, w_z;
    logic                w_hit;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [OFFSET_W:0]   w_off_inc;
    logic [OFFSET_W:0]   w_twice_r;
    t_phase              n_phase;
    logic [OFFSET_W-1:0] n_offset;
    logic [RADIUS_W-1:0] n_radius;

    assign w_total   = CNT_W'(i_size) * CNT_W'(i_size);
    assign w_szm1    = i_size - SIZE_W'(1);
    assign w_cnt_inc = r_cnt + CNT_W'(1);

    // Clamp the start centre into the grid
    assign w_clamp_x = (SIZE_W'(i_center_x) > w_szm1) ? w_szm1[COORD_W-1:0] : i_center_x;
    assign w_clamp_z = (SIZE_W'(i_center_z) > w_szm1) ? w_szm1[COORD_W-1:0] : i_center_z;

    // Candidate position on the current ring
    assign w_cx  = $signed(CW'(r_center_x));
    assign w_cz  = $signed(CW'(r_center_z));
    assign w_r   = $signed(CW'(r_radius));
    assign w_off = $signed(CW'(r_offset));
    assign w_sz  = $signed(CW'(i_size));

    always_comb begin
        case (r_phase)
            PH_RIGHT: begin
                w_x = w_cx + w_r;
                w_z = w_cz + w_off - w_r;
            end
            PH_LEFT: begin
                w_x = w_cx - w_r;
                w_z = w_cz + w_off - w_r;
            end
            PH_BOTTOM: begin
                w_x = w_cx + w_off - w_r + CW'(1);
                w_z = w_cz + w_r;
            end
            PH_TOP: begin
                w_x = w_cx + w_off - w_r + CW'(1);
                w_z = w_cz - w_r;
            end
            default: begin
                w_x = '0;
                w_z = '0;
            end
        endcase
    end

    assign w_hit = !w_x[CW-1] && !w_z[CW-1] && (w_x < w_sz) && (w_z < w_sz);

    // Step to the next ring position
    assign w_off_inc = (OFFSET_W+1)'(r_offset) + (OFFSET_W+1)'(1);
    assign w_twice_r = (OFFSET_W+1)'({r_radius, 1'b0});

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_radius = r_radius;
        case (r_phase)
            PH_RIGHT: begin
                n_phase = PH_LEFT;
            end
            PH_LEFT: begin
                if (w_off_inc > w_twice_r) begin
                    n_phase  = PH_BOTTOM;
                    n_offset = '0;
                end else begin
                    n_phase  = PH_RIGHT;
                    n_offset = w_off_inc[OFFSET_W-1:0];
                end
            end
            PH_BOTTOM: begin
                n_phase = PH_TOP;
            end
            PH_TOP: begin
                if (w_off_inc + (OFFSET_W+1)'(2) > w_twice_r) begin
                    n_phase  = PH_RIGHT;
                    n_offset = '0;
                    n_radius = r_radius + RADIUS_W'(1);
                end else begin
                    n_phase  = PH_BOTTOM;
                    n_offset = w_off_inc[OFFSET_W-1:0];
                end
            end
            default: begin
                n_phase = PH_RIGHT;
            end
        endcase
    end

    // Walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_z <= '0;
            r_radius   <= '0;
            r_phase    <= PH_RIGHT;
            r_offset   <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.start) begin
            r_center_x <= w_clamp_x;
            r_center_z <= w_clamp_z;
            r_radius   <= RADIUS_W'(1);
            r_phase    <= PH_RIGHT;
            r_offset   <= '0;
            r_cnt      <= CNT_W'(1);
        end else if (i_cmd.step) begin
            r_radius <= n_radius;
            r_phase  <= n_phase;
            r_offset <= n_offset;
            if (w_hit) begin
                r_cnt <= w_cnt_inc;
            end
        end
    end

    // Found cell
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit_x    <= w_clamp_x;
            r_hit_z    <= w_clamp_z;
            r_hit_last <= (w_total == CNT_W'(1));
            r_hit_exh  <= 1'b0;
        end else if (i_cmd.done) begin
            r_hit_x    <= '0;
            r_hit_z    <= '0;
            r_hit_last <= 1'b0;
            r_hit_exh  <= 1'b1;
        end else if (i_cmd.step && w_hit) begin
            r_hit_x    <= w_x[COORD_W-1:0];
            r_hit_z    <= w_z[COORD_W-1:0];
            r_hit_last <= (w_cnt_inc == w_total);
            r_hit_exh  <= 1'b0;
        end
    end

    // Output register: the linear index is formed on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_index <= INDEX_W'(r_hit_z * i_size + CNT_W'(r_hit_x));
            r_out_x     <= r_hit_x;
            r_out_z     <= r_hit_z;
            r_out_last  <= r_hit_last;
            r_out_exh   <= r_hit_exh;
        end
    end

    // Status to the controller
    assign o_sts.no_scan  = (r_cnt == '0) || (r_cnt >= w_total);
    assign o_sts.ring_end = (r_radius >= i_size);
    assign o_sts.hit      = w_hit;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cell_index = r_out_index;
    assign o_cell_x     = r_out_x;
    assign o_cell_z     = r_out_z;
    assign o_is_last    = r_out_last;
    assign o_exhausted  = r_out_exh;

endmodule

// ===== hw/rtl/square_spiral_scan_order.sv =====
// Flow: a start transaction, or a next with nothing started or all cells given,
// loads the found-cell register on acceptance, then the output register once the
// output is free; any other next first walks the ring, one candidate per cycle,
// skipping off-grid positions until a hit or the grid edge. One transaction at a
// time: input ready returns once the result is loaded; a stalled output delays it.
// Reset (synchronous, active low): grid size 256, nothing started, output empty.
`include "assert_macros.svh"

module square_spiral_scan_order import sssc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    sssc_in_if.sink               i_in,
    sssc_out_if.source            o_out
);

    logic [SIZE_W-1:0] w_size;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_cell_ok;
    logic              w_blank;

    // Configuration register
    sssc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_size  (w_size)
    );

    // Sequencer
    sssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Ring walker and output register
    sssc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_size       (w_size),
        .i_center_x   (i_in.center_x),
        .i_center_z   (i_in.center_z),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_cell_index (o_out.cell_index),
        .o_cell_x     (o_out.cell_x),
        .o_cell_z     (o_out.cell_z),
        .o_is_last    (o_out.is_last),
        .o_exhausted  (o_out.exhausted)
    );

    // Checks
    assign w_cell_ok = (o_out.cell_x < w_size) && (o_out.cell_z < w_size);
    assign w_blank   = (o_out.cell_index == '0) && (o_out.cell_x == '0) &&
                       (o_out.cell_z == '0) && !o_out.is_last;

    `SSSC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `SSSC_ASSERT_IMP(a_cell_in_grid, i_clk, i_rst_n, o_out.valid && !o_out.exhausted, w_cell_ok)
    `SSSC_ASSERT_IMP(a_done_is_blank, i_clk, i_rst_n, o_out.valid && o_out.exhausted, w_blank)

endmodule
